// File: rtl/core/pidaw_pkg.sv
// shared types, constants and helpers for the pid controller with angle wrap
`default_nettype none

package pidaw_pkg;

   localparam int unsigned TIME_UNITS_PER_SECOND = 1000000;

   localparam int DATA_W   = 32;
   localparam int GAIN_W   = 20;
   localparam int TIME_W   = 20;
   localparam int CSR_AW   = 3;
   localparam int REQ_W    = 56;
   localparam int RSP_W    = 168;

   // datapath widths
   localparam int MUL_A_W  = 33;
   localparam int MUL_B_W  = 32;
   localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
   localparam int PROD_W   = 52;
   localparam int NUM_W    = 52;
   localparam int DEN_W    = 36;
   localparam int N_W      = 53;
   localparam int ACC_W    = 85;

   localparam int STEPS_PER_CYCLE = 2;
   localparam int INC_DIV_CYCLES  = PROD_W / STEPS_PER_CYCLE;
   localparam int D_DIV_CYCLES    = DATA_W / STEPS_PER_CYCLE;
   localparam int CNT_W           = $clog2(INC_DIV_CYCLES + 1);

   localparam logic signed [33:0] HALF_TURN = 34'sd11796480;
   localparam logic signed [33:0] FULL_TURN = 34'sd23592960;

   localparam logic [NUM_W-1:0] MAG_CAP = 52'h0_0000_8000_0000;

   // register indexes
   localparam logic [CSR_AW-1:0] CSR_SETPOINT   = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_PROP_GAIN  = 3'd1;
   localparam logic [CSR_AW-1:0] CSR_INT_GAIN   = 3'd2;
   localparam logic [CSR_AW-1:0] CSR_DERIV_GAIN = 3'd3;
   localparam logic [CSR_AW-1:0] CSR_OUT_LOW    = 3'd4;
   localparam logic [CSR_AW-1:0] CSR_OUT_HIGH   = 3'd5;
   localparam logic [CSR_AW-1:0] CSR_ANGLE_MODE = 3'd6;

   // opcodes
   localparam logic OP_STEP  = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   typedef enum logic [4:0] {
      S_IDLE,
      S_ERR,
      S_WRAP,
      S_DELTA,
      S_INC_MUL,
      S_INC_LOAD,
      S_INC_DIV,
      S_INT_ADD,
      S_P_TERM,
      S_I_LO,
      S_I_HI,
      S_I_FIN,
      S_X_LO,
      S_X_HI,
      S_X_SUM,
      S_D_LOAD,
      S_D_DIV,
      S_D_FIN,
      S_SUM,
      S_EMIT
   } state_type;

   // sign and magnitude to saturated 32 bit signed
   function automatic logic [DATA_W-1:0] cap_mag(input logic neg, input logic [NUM_W-1:0] mag);
      if (neg) begin
         if (mag >= MAG_CAP) return 32'h8000_0000;
         return ~mag[DATA_W-1:0] + 32'd1;
      end
      if (mag >= MAG_CAP) return 32'h7FFF_FFFF;
      return mag[DATA_W-1:0];
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/pid_controller_angle_wrap_core.sv
// pid controller with angle wrap, integral saturation and output clamp
// a control item computes error, integral increment, p, i and d terms, then the clamp;
// the derivative division is skipped if elapsed time is zero or the derivative saturates
// a clear item goes straight to the response; a new item waits until the last is emitted
// the radix-4 divider is shared by both quotients, the 33x32 multiplier by seven products
// reset: synchronous; registers go to their reset values, integral and prior error are zeroed
`default_nettype none

module pid_controller_angle_wrap_core
   import pidaw_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [CSR_AW-1:0]   csr_addr,
   input  logic [DATA_W-1:0]   csr_wdata,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [REQ_W-1:0]    req_tdata,   // measured_value, elapsed_us, zero pad
   input  logic                req_tuser,   // opcode
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RSP_W-1:0]    rsp_tdata    // drive_value, error_value, p_term, i_term,
                                            // d_term, limited, zero pad
);

   state_type state_ff, state_in;

   // configuration
   logic signed [DATA_W-1:0] setpoint_ff;
   logic [GAIN_W-1:0]        prop_gain_ff;
   logic [GAIN_W-1:0]        int_gain_ff;
   logic [GAIN_W-1:0]        deriv_gain_ff;
   logic signed [DATA_W-1:0] out_low_ff;
   logic signed [DATA_W-1:0] out_high_ff;
   logic                     angle_mode_ff;

   // controller state
   logic signed [63:0]       integral_ff;
   logic signed [DATA_W-1:0] prior_ff;

   // working registers
   logic signed [DATA_W-1:0] mv_ff;
   logic [TIME_W-1:0]        elapsed_ff;
   logic signed [DATA_W:0]   err_raw_ff;
   logic signed [DATA_W-1:0] err_ff;
   logic [DATA_W-1:0]        err_mag_ff;
   logic                     err_neg_ff;
   logic [DATA_W:0]          delta_mag_ff;
   logic                     delta_neg_ff;
   logic [63:0]              int_mag_ff;
   logic                     int_neg_ff;
   logic signed [DATA_W-1:0] p_ff;
   logic signed [DATA_W-1:0] i_ff;
   logic signed [DATA_W-1:0] d_ff;
   logic signed [DATA_W-1:0] drive_ff;
   logic                     limited_ff;
   logic [MUL_P_W-1:0]       mul_ff;
   logic [ACC_W-1:0]         acc_ff;
   logic [N_W-1:0]           n_ff;
   logic [NUM_W-1:0]         num_ff;
   logic [DEN_W-1:0]         rem_ff;
   logic [DEN_W-1:0]         den_ff;
   logic [CNT_W-1:0]         cnt_ff;
   logic                     rsp_tvalid_ff;
   logic [RSP_W-1:0]         rsp_data_ff;

   // combinational
   logic                     req_accept;
   logic                     rsp_free;
   logic [MUL_A_W-1:0]       mul_a;
   logic [MUL_B_W-1:0]       mul_b;
   logic signed [33:0]       err_ext;
   logic signed [33:0]       err_wrapped;
   logic signed [DATA_W-1:0] err_sat;
   logic signed [DATA_W:0]   delta;
   logic [DATA_W:0]          delta_mag;
   logic signed [52:0]       inc_val;
   logic signed [64:0]       int_sum;
   logic signed [63:0]       int_next;
   logic [67:0]              i_total;
   logic [DATA_W-1:0]        i_val;
   logic [ACC_W-1:0]         x_sum;
   logic [DEN_W-1:0]         den_d;
   logic                     d_cap;
   logic signed [33:0]       sum_ext;
   logic [DEN_W:0]           div_trial;
   logic [DEN_W-1:0]         div_rem;
   logic [NUM_W-1:0]         div_num;

   localparam logic [MUL_B_W-1:0] TPS_B   = MUL_B_W'(TIME_UNITS_PER_SECOND);
   localparam logic [DEN_W-1:0]   TPS_DEN = DEN_W'(TIME_UNITS_PER_SECOND);

   assign req_accept = req_tvalid && req_tready;
   assign rsp_free   = !rsp_tvalid_ff || rsp_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // error wrap and saturation
   always_comb begin
      err_ext     = {err_raw_ff[DATA_W], err_raw_ff};
      err_wrapped = err_ext;
      if (angle_mode_ff && (err_ext > HALF_TURN)) begin
         err_wrapped = err_ext - FULL_TURN;
      end else if (angle_mode_ff && (err_ext < -HALF_TURN)) begin
         err_wrapped = err_ext + FULL_TURN;
      end
      if (err_wrapped > 34'sd2147483647) begin
         err_sat = 32'sh7FFF_FFFF;
      end else if (err_wrapped < -34'sd2147483648) begin
         err_sat = 32'sh8000_0000;
      end else begin
         err_sat = err_wrapped[DATA_W-1:0];
      end
   end

   assign delta     = {err_ff[DATA_W-1], err_ff} - {prior_ff[DATA_W-1], prior_ff};
   assign delta_mag = delta[DATA_W] ? (~delta + 33'd1) : delta;

   // integral update with 64 bit saturation
   always_comb begin
      inc_val = err_neg_ff ? -$signed({1'b0, num_ff}) : $signed({1'b0, num_ff});
      int_sum = {integral_ff[63], integral_ff} + {{12{inc_val[52]}}, inc_val};
      if (int_sum[64] != int_sum[63]) begin
         int_next = int_sum[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
      end else begin
         int_next = int_sum[63:0];
      end
   end

   // integral term from the two partial products
   always_comb begin
      i_total = acc_ff[67:0] + {mul_ff[35:0], 32'd0};
      if (int_gain_ff == '0) begin
         i_val = '0;
      end else if (|int_mag_ff[63:47]) begin
         i_val = cap_mag(int_neg_ff, MAG_CAP);
      end else begin
         i_val = cap_mag(int_neg_ff, i_total[67:16]);
      end
   end

   assign x_sum = acc_ff + {mul_ff[N_W-1:0], 32'd0};
   assign den_d = {elapsed_ff, 16'd0};
   // quotient would reach 2^31
   assign d_cap = acc_ff[ACC_W-1:31] >= {18'd0, den_d};

   assign sum_ext = {{2{p_ff[DATA_W-1]}}, p_ff} + {{2{i_ff[DATA_W-1]}}, i_ff}
                  + {{2{d_ff[DATA_W-1]}}, d_ff};

   // restoring divider, two quotient bits per cycle
   always_comb begin
      div_rem   = rem_ff;
      div_num   = num_ff;
      div_trial = '0;
      for (int k = 0; k < STEPS_PER_CYCLE; k++) begin
         div_trial = {div_rem, div_num[NUM_W-1]};
         div_num   = {div_num[NUM_W-2:0], 1'b0};
         if (div_trial >= {1'b0, den_ff}) begin
            div_trial  = div_trial - {1'b0, den_ff};
            div_num[0] = 1'b1;
         end
         div_rem = div_trial[DEN_W-1:0];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) state_in = (req_tuser == OP_CLEAR) ? S_EMIT : S_ERR;
         end
         S_ERR:      state_in = S_WRAP;
         S_WRAP:     state_in = S_DELTA;
         S_DELTA:    state_in = S_INC_MUL;
         S_INC_MUL:  state_in = S_INC_LOAD;
         S_INC_LOAD: state_in = S_INC_DIV;
         S_INC_DIV: begin
            if (cnt_ff == CNT_W'(1)) state_in = S_INT_ADD;
         end
         S_INT_ADD:  state_in = S_P_TERM;
         S_P_TERM:   state_in = S_I_LO;
         S_I_LO:     state_in = S_I_HI;
         S_I_HI:     state_in = S_I_FIN;
         S_I_FIN:    state_in = S_X_LO;
         S_X_LO:     state_in = S_X_HI;
         S_X_HI:     state_in = S_X_SUM;
         S_X_SUM:    state_in = S_D_LOAD;
         S_D_LOAD: begin
            state_in = ((elapsed_ff == '0) || d_cap) ? S_SUM : S_D_DIV;
         end
         S_D_DIV: begin
            if (cnt_ff == CNT_W'(1)) state_in = S_D_FIN;
         end
         S_D_FIN:    state_in = S_SUM;
         S_SUM:      state_in = S_EMIT;
         S_EMIT: begin
            if (rsp_free) state_in = S_IDLE;
         end
         default:    state_in = S_IDLE;
      endcase
   end

   // outputs: handshake and multiplier operands
   always_comb begin
      req_tready = (state_ff == S_IDLE);
      mul_a      = '0;
      mul_b      = '0;
      unique case (state_ff)
         S_INC_MUL: begin
            mul_a = {1'b0, err_mag_ff};
            mul_b = {12'd0, elapsed_ff};
         end
         S_INT_ADD: begin
            mul_a = {1'b0, err_mag_ff};
            mul_b = {12'd0, prop_gain_ff};
         end
         S_I_LO: begin
            mul_a = {1'b0, int_mag_ff[31:0]};
            mul_b = {12'd0, int_gain_ff};
         end
         S_I_HI: begin
            mul_a = {18'd0, int_mag_ff[46:32]};
            mul_b = {12'd0, int_gain_ff};
         end
         S_I_FIN: begin
            mul_a = delta_mag_ff;
            mul_b = {12'd0, deriv_gain_ff};
         end
         S_X_LO: begin
            mul_a = {1'b0, mul_ff[31:0]};
            mul_b = TPS_B;
         end
         S_X_HI: begin
            mul_a = {12'd0, n_ff[N_W-1:32]};
            mul_b = TPS_B;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // control and persistent state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         setpoint_ff   <= '0;
         prop_gain_ff  <= '0;
         int_gain_ff   <= '0;
         deriv_gain_ff <= '0;
         out_low_ff    <= -32'sd65536;
         out_high_ff   <= 32'sd65536;
         angle_mode_ff <= 1'b0;
         integral_ff   <= '0;
         prior_ff      <= '0;
         cnt_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            unique case (csr_addr)
               CSR_SETPOINT:   setpoint_ff   <= csr_wdata;
               CSR_PROP_GAIN:  prop_gain_ff  <= csr_wdata[GAIN_W-1:0];
               CSR_INT_GAIN:   int_gain_ff   <= csr_wdata[GAIN_W-1:0];
               CSR_DERIV_GAIN: deriv_gain_ff <= csr_wdata[GAIN_W-1:0];
               CSR_OUT_LOW:    out_low_ff    <= csr_wdata;
               CSR_OUT_HIGH:   out_high_ff   <= csr_wdata;
               CSR_ANGLE_MODE: angle_mode_ff <= csr_wdata[0];
               default:        ;
            endcase
         end
         if (req_accept && (req_tuser == OP_CLEAR)) integral_ff <= '0;
         if (state_ff == S_INT_ADD) integral_ff <= int_next;
         if (state_ff == S_DELTA) prior_ff <= err_ff;
         if (state_ff == S_INC_LOAD) begin
            cnt_ff <= CNT_W'(INC_DIV_CYCLES);
         end else if (state_ff == S_D_LOAD) begin
            cnt_ff <= CNT_W'(D_DIV_CYCLES);
         end else if ((state_ff == S_INC_DIV) || (state_ff == S_D_DIV)) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
         end
         if ((state_ff == S_EMIT) && rsp_free) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      mul_ff <= mul_a * mul_b;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               mv_ff      <= req_tdata[DATA_W-1:0];
               elapsed_ff <= req_tdata[DATA_W+TIME_W-1:DATA_W];
               // a clear item reports all zeros
               err_ff     <= '0;
               p_ff       <= '0;
               i_ff       <= '0;
               d_ff       <= '0;
               drive_ff   <= '0;
               limited_ff <= 1'b0;
            end
         end
         S_ERR: begin
            err_raw_ff <= {setpoint_ff[DATA_W-1], setpoint_ff} - {mv_ff[DATA_W-1], mv_ff};
         end
         S_WRAP: begin
            err_ff <= err_sat;
         end
         S_DELTA: begin
            err_neg_ff   <= err_ff[DATA_W-1];
            err_mag_ff   <= err_ff[DATA_W-1] ? (~err_ff + 32'd1) : err_ff;
            delta_neg_ff <= delta[DATA_W];
            delta_mag_ff <= delta_mag;
         end
         S_INC_LOAD: begin
            num_ff <= mul_ff[PROD_W-1:0];
            rem_ff <= '0;
            den_ff <= TPS_DEN;
         end
         S_INC_DIV, S_D_DIV: begin
            num_ff <= div_num;
            rem_ff <= div_rem;
         end
         S_P_TERM: begin
            p_ff       <= cap_mag(err_neg_ff, {16'd0, mul_ff[51:16]});
            int_neg_ff <= integral_ff[63];
            int_mag_ff <= integral_ff[63] ? (~integral_ff + 64'd1) : integral_ff;
         end
         S_I_HI: begin
            acc_ff <= {21'd0, mul_ff[63:0]};
         end
         S_I_FIN: begin
            i_ff <= i_val;
         end
         S_X_LO: begin
            n_ff <= mul_ff[N_W-1:0];
         end
         S_X_HI: begin
            acc_ff <= {21'd0, mul_ff[63:0]};
         end
         S_X_SUM: begin
            acc_ff <= x_sum;
         end
         S_D_LOAD: begin
            if (elapsed_ff == '0) begin
               d_ff <= '0;
            end else if (d_cap) begin
               d_ff <= cap_mag(delta_neg_ff, MAG_CAP);
            end else begin
               rem_ff <= acc_ff[67:32];
               num_ff <= {acc_ff[31:0], 20'd0};
               den_ff <= den_d;
            end
         end
         S_D_FIN: begin
            d_ff <= cap_mag(delta_neg_ff, {20'd0, num_ff[31:0]});
         end
         S_SUM: begin
            if (sum_ext > $signed({{2{out_high_ff[DATA_W-1]}}, out_high_ff})) begin
               drive_ff   <= out_high_ff;
               limited_ff <= 1'b1;
            end else if (sum_ext < $signed({{2{out_low_ff[DATA_W-1]}}, out_low_ff})) begin
               drive_ff   <= out_low_ff;
               limited_ff <= 1'b1;
            end else begin
               drive_ff   <= sum_ext[DATA_W-1:0];
               limited_ff <= 1'b0;
            end
         end
         S_EMIT: begin
            if (rsp_free) begin
               rsp_data_ff <= {7'd0, limited_ff, d_ff, i_ff, p_ff, err_ff, drive_ff};
            end
         end
         default: ;
      endcase
   end

   // a clear item leaves the integral at zero
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_tuser == OP_CLEAR)) |=> (integral_ff == '0))
      else $error("integral not cleared");

   // divider count never runs out inside a division
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_INC_DIV) || (state_ff == S_D_DIV)) |-> (cnt_ff != '0))
      else $error("divider count underflow");

   // without the cap the derivative quotient stays below 2^31
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_D_FIN) |-> (num_ff[31] == 1'b0))
      else $error("derivative quotient overflow");

   // a limited drive sits on one of the clamp limits
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SUM) |=>
         (!limited_ff || (drive_ff == out_high_ff) || (drive_ff == out_low_ff)))
      else $error("limited drive off the clamp limits");

endmodule

`default_nettype wire
